// ===== rtl/drq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drq_pkg
// Shared types, codes and helper functions of the two-queue runway scheduler.
// ----------------------------------------------------------------------------
package drq_pkg;

   localparam int QueueDepth = 16;
   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam int SumWidth   = CountWidth + 1;
   localparam int LimitWidth = 5;
   localparam int CmpWidth   = (CountWidth > LimitWidth) ? CountWidth : LimitWidth;
   localparam int LevelWidth = 5;

   // Request kinds.
   localparam logic [1:0] ReqLand    = 2'd0;
   localparam logic [1:0] ReqTakeoff = 2'd1;
   localparam logic [1:0] ReqTick    = 2'd2;
   localparam logic [1:0] ReqNone    = 2'd3;

   // Result status codes.
   localparam logic [2:0] StatusAccepted = 3'd0;
   localparam logic [2:0] StatusRefused  = 3'd1;
   localparam logic [2:0] StatusIdle     = 3'd2;
   localparam logic [2:0] StatusLanded   = 3'd3;
   localparam logic [2:0] StatusTookOff  = 3'd4;
   localparam logic [2:0] StatusBoth     = 3'd5;

   localparam logic [LimitWidth-1:0] LimitReset = LimitWidth'(16);

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] plane_id;
      logic [31:0] now;
   } req_item_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [15:0]           first_plane;
      logic [15:0]           second_plane;
      logic [LevelWidth-1:0] land_level;
      logic [LevelWidth-1:0] takeoff_level;
      logic [47:0]           land_wait_total;
      logic [47:0]           takeoff_wait_total;
      logic [31:0]           idle_ticks;
      logic [31:0]           land_refused_total;
      logic [31:0]           takeoff_refused_total;
      logic [31:0]           landings_total;
      logic [31:0]           takeoffs_total;
   } rsp_item_type;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] plane_id;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic [15:0] plane_id;
      logic [31:0] arrival;
   } slot_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] value);
      return (value == '1) ? value : value + 32'd1;
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] sum,
                                             input logic [31:0] delta);
      logic [48:0] total;
      total = {1'b0, sum} + {17'd0, delta};
      return total[48] ? '1 : total[47:0];
   endfunction

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] ptr);
      return (ptr == PtrWidth'(QueueDepth - 1)) ? '0 : ptr + PtrWidth'(1);
   endfunction

   function automatic logic [PtrWidth-1:0] tail_ptr(input logic [PtrWidth-1:0]   head,
                                                    input logic [CountWidth-1:0] count);
      logic [SumWidth-1:0] sum;
      sum = SumWidth'(head) + SumWidth'(count);
      if (sum >= SumWidth'(QueueDepth)) begin
         sum = sum - SumWidth'(QueueDepth);
      end
      return PtrWidth'(sum);
   endfunction

   function automatic logic has_room(input logic [CountWidth-1:0] count,
                                     input logic [LimitWidth-1:0] limit);
      return (CmpWidth'(count) < CmpWidth'(limit)) && (count < CountWidth'(QueueDepth));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/drq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drq_front
// Accepts request transactions, classifies them and holds them in a
// two-entry command queue for the back end. Unknown request kinds are dropped.
// ----------------------------------------------------------------------------
module drq_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire drq_pkg::req_item_type req_data,
   output logic                       cmd_valid,
   input  wire                        cmd_take,
   output drq_pkg::cmd_type           cmd_data
);

   drq_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      push      = req_valid && req_ready && (req_data.req_type != drq_pkg::ReqNone);
      pop       = cmd_take && cmd_valid;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{kind:     req_data.req_type,
                                  plane_id: req_data.plane_id,
                                  now:      req_data.now};
      end
   end

endmodule
`default_nettype wire

// ===== rtl/drq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drq_back
// Carries out one command a cycle while the result channel is not stalled:
// pushes to or pops from the landing and takeoff queues, keeps the wait
// totals and event counters, and registers the result transaction.
// ----------------------------------------------------------------------------
module drq_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [drq_pkg::LimitWidth-1:0]      max_waiting,
   input  wire                                 cmd_valid,
   output logic                                cmd_take,
   input  wire  drq_pkg::cmd_type              cmd_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output drq_pkg::rsp_item_type               rsp_data
);

   drq_pkg::slot_type land_mem_ff    [drq_pkg::QueueDepth];
   drq_pkg::slot_type takeoff_mem_ff [drq_pkg::QueueDepth];

   logic [drq_pkg::PtrWidth-1:0]   land_head_ff, land_head_in;
   logic [drq_pkg::PtrWidth-1:0]   takeoff_head_ff, takeoff_head_in;
   logic [drq_pkg::CountWidth-1:0] land_count_ff, land_count_in;
   logic [drq_pkg::CountWidth-1:0] takeoff_count_ff, takeoff_count_in;
   logic [47:0] land_wait_ff, land_wait_in;
   logic [47:0] takeoff_wait_ff, takeoff_wait_in;
   logic [31:0] idle_ff, idle_in;
   logic [31:0] land_ref_ff, land_ref_in;
   logic [31:0] takeoff_ref_ff, takeoff_ref_in;
   logic [31:0] landings_ff, landings_in;
   logic [31:0] takeoffs_ff, takeoffs_in;
   logic        rsp_valid_ff, rsp_valid_in;
   drq_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic land_wr, takeoff_wr;
   logic [drq_pkg::PtrWidth-1:0] land_tail, takeoff_tail;
   drq_pkg::slot_type land_slot, takeoff_slot;
   logic land_busy, takeoff_busy;
   logic [2:0]  status;
   logic [15:0] first_plane, second_plane;

   assign cmd_take     = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign land_tail    = drq_pkg::tail_ptr(land_head_ff, land_count_ff);
   assign takeoff_tail = drq_pkg::tail_ptr(takeoff_head_ff, takeoff_count_ff);
   assign land_slot    = land_mem_ff[land_head_ff];
   assign takeoff_slot = takeoff_mem_ff[takeoff_head_ff];
   assign land_busy    = (land_count_ff != '0);
   assign takeoff_busy = (takeoff_count_ff != '0);

   always_comb begin
      land_head_in     = land_head_ff;
      takeoff_head_in  = takeoff_head_ff;
      land_count_in    = land_count_ff;
      takeoff_count_in = takeoff_count_ff;
      land_wait_in     = land_wait_ff;
      takeoff_wait_in  = takeoff_wait_ff;
      idle_in          = idle_ff;
      land_ref_in      = land_ref_ff;
      takeoff_ref_in   = takeoff_ref_ff;
      landings_in      = landings_ff;
      takeoffs_in      = takeoffs_ff;
      land_wr          = 1'b0;
      takeoff_wr       = 1'b0;
      status           = drq_pkg::StatusAccepted;
      first_plane      = 16'd0;
      second_plane     = 16'd0;

      if (cmd_take) begin
         case (cmd_data.kind)
            drq_pkg::ReqLand: begin
               if (drq_pkg::has_room(land_count_ff, max_waiting)) begin
                  land_wr       = 1'b1;
                  land_count_in = land_count_ff + drq_pkg::CountWidth'(1);
               end else begin
                  status      = drq_pkg::StatusRefused;
                  land_ref_in = drq_pkg::sat_inc32(land_ref_ff);
               end
            end
            drq_pkg::ReqTakeoff: begin
               if (drq_pkg::has_room(takeoff_count_ff, max_waiting)) begin
                  takeoff_wr       = 1'b1;
                  takeoff_count_in = takeoff_count_ff + drq_pkg::CountWidth'(1);
               end else begin
                  status         = drq_pkg::StatusRefused;
                  takeoff_ref_in = drq_pkg::sat_inc32(takeoff_ref_ff);
               end
            end
            drq_pkg::ReqTick: begin
               // Landing is reported first; both heads go when both queues wait.
               if (land_busy) begin
                  land_head_in  = drq_pkg::next_ptr(land_head_ff);
                  land_count_in = land_count_ff - drq_pkg::CountWidth'(1);
                  land_wait_in  = drq_pkg::sat_add48(land_wait_ff,
                                                     cmd_data.now - land_slot.arrival);
                  landings_in   = drq_pkg::sat_inc32(landings_ff);
                  first_plane   = land_slot.plane_id;
               end
               if (takeoff_busy) begin
                  takeoff_head_in  = drq_pkg::next_ptr(takeoff_head_ff);
                  takeoff_count_in = takeoff_count_ff - drq_pkg::CountWidth'(1);
                  takeoff_wait_in  = drq_pkg::sat_add48(takeoff_wait_ff,
                                                        cmd_data.now - takeoff_slot.arrival);
                  takeoffs_in      = drq_pkg::sat_inc32(takeoffs_ff);
               end
               if (land_busy && takeoff_busy) begin
                  status       = drq_pkg::StatusBoth;
                  second_plane = takeoff_slot.plane_id;
               end else if (land_busy) begin
                  status = drq_pkg::StatusLanded;
               end else if (takeoff_busy) begin
                  status      = drq_pkg::StatusTookOff;
                  first_plane = takeoff_slot.plane_id;
               end else begin
                  status  = drq_pkg::StatusIdle;
                  idle_in = drq_pkg::sat_inc32(idle_ff);
               end
            end
            default: begin
               status = drq_pkg::StatusAccepted;
            end
         endcase
      end

      rsp_data_in = '{status:                status,
                      first_plane:           first_plane,
                      second_plane:          second_plane,
                      land_level:            drq_pkg::LevelWidth'(land_count_in),
                      takeoff_level:         drq_pkg::LevelWidth'(takeoff_count_in),
                      land_wait_total:       land_wait_in,
                      takeoff_wait_total:    takeoff_wait_in,
                      idle_ticks:            idle_in,
                      land_refused_total:    land_ref_in,
                      takeoff_refused_total: takeoff_ref_in,
                      landings_total:        landings_in,
                      takeoffs_total:        takeoffs_in};

      rsp_valid_in = cmd_take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         land_head_ff     <= '0;
         takeoff_head_ff  <= '0;
         land_count_ff    <= '0;
         takeoff_count_ff <= '0;
         land_wait_ff     <= '0;
         takeoff_wait_ff  <= '0;
         idle_ff          <= '0;
         land_ref_ff      <= '0;
         takeoff_ref_ff   <= '0;
         landings_ff      <= '0;
         takeoffs_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         land_head_ff     <= land_head_in;
         takeoff_head_ff  <= takeoff_head_in;
         land_count_ff    <= land_count_in;
         takeoff_count_ff <= takeoff_count_in;
         land_wait_ff     <= land_wait_in;
         takeoff_wait_ff  <= takeoff_wait_in;
         idle_ff          <= idle_in;
         land_ref_ff      <= land_ref_in;
         takeoff_ref_ff   <= takeoff_ref_in;
         landings_ff      <= landings_in;
         takeoffs_ff      <= takeoffs_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (land_wr) begin
         land_mem_ff[land_tail] <= '{plane_id: cmd_data.plane_id, arrival: cmd_data.now};
      end
      if (takeoff_wr) begin
         takeoff_mem_ff[takeoff_tail] <= '{plane_id: cmd_data.plane_id,
                                           arrival:  cmd_data.now};
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dual_queue_runway_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_queue_runway_scheduler
// Landing and takeoff queues with a runway tick that serves their heads.
// ----------------------------------------------------------------------------
// Each request transaction is either a landing request, a takeoff request or
// a runway tick, and each yields exactly one result transaction; the unused
// request kind three is taken and dropped without a result. The block
// sustains one request per clock while the result channel is not stalled: a
// two-entry command queue in the front end takes a transaction whenever it is
// not full, and the back end retires one command a cycle into its output
// register while the result channel is not stalled, so a request is held in
// the command queue and then in the output register before its result is
// presented. The configuration register caps each queue at min(value, 16)
// planes and should be written only while no transaction is in flight.
module dual_queue_runway_scheduler (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire drq_pkg::req_item_type   req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output drq_pkg::rsp_item_type        rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [drq_pkg::LimitWidth-1:0] csr_data
);

   logic [drq_pkg::LimitWidth-1:0] max_waiting_ff, max_waiting_in;
   logic             cmd_valid;
   logic             cmd_take;
   drq_pkg::cmd_type cmd_data;

   assign csr_ready      = 1'b1;
   assign max_waiting_in = (csr_valid && csr_ready) ? csr_data : max_waiting_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_waiting_ff <= drq_pkg::LimitReset;
      end else begin
         max_waiting_ff <= max_waiting_in;
      end
   end

   drq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   drq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_waiting (max_waiting_ff),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .cmd_data    (cmd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // An idle tick can only be reported when both queues are empty.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == drq_pkg::StatusIdle) |->
         (rsp_data.land_level == '0 && rsp_data.takeoff_level == '0))
      else $error("idle tick reported with a nonempty queue");

   // A lone landing means the takeoff queue was empty.
   a_land_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == drq_pkg::StatusLanded) |->
         (rsp_data.takeoff_level == '0 && rsp_data.second_plane == 16'd0))
      else $error("landing served alone while takeoff queue waited");

   // Requests and idle ticks carry no plane ids.
   a_no_plane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == drq_pkg::StatusAccepted ||
                     rsp_data.status == drq_pkg::StatusRefused ||
                     rsp_data.status == drq_pkg::StatusIdle)) |->
         (rsp_data.first_plane == 16'd0 && rsp_data.second_plane == 16'd0))
      else $error("plane id reported on a result that serves no plane");

endmodule
`default_nettype wire
